// ===== rtl/infix_to_postfix_converter_unit_assert.svh =====
// Assertion macros used by itp_stack; empty when SYNTH is set.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define ITP_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("itp: same-cycle check failed");
// next-cycle implication
`define ITP_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("itp: next-cycle check failed");
`else
`define ITP_ASSERT_IMP(name, ante, cons)
`define ITP_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== rtl/itp_pkg.sv =====
`timescale 1ns / 1ps

package itp_pkg;

   // operator stack geometry
   localparam int STACK_DEPTH = 32;
   localparam int TOP_W       = $clog2(STACK_DEPTH);

   // ASCII characters of interest
   localparam logic [7:0] CH_MUL    = 8'h2A;
   localparam logic [7:0] CH_DIV    = 8'h2F;
   localparam logic [7:0] CH_ADD    = 8'h2B;
   localparam logic [7:0] CH_SUB    = 8'h2D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_DOT    = 8'h2E;

   // result error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_INVALID   = 3'd1;
   localparam logic [2:0] ERR_UNMATCHED = 3'd2;
   localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
   localparam logic [2:0] ERR_UNCLOSED  = 3'd4;

   // rank that no stacked symbol reaches: '(' pops nothing
   localparam logic [1:0] RANK_NONE = 2'd3;

   // compact code of a stacked symbol
   typedef enum logic [2:0] {
      CODE_LPAREN = 3'd0,
      CODE_ADD    = 3'd1,
      CODE_SUB    = 3'd2,
      CODE_MUL    = 3'd3,
      CODE_DIV    = 3'd4
   } op_code_type;

   // stack command from the sequencer
   typedef struct packed {
      logic        push;
      logic        pop;
      logic        clear;
      op_code_type code;
      logic [1:0]  min_rank;
   } stk_cmd_type;

   // stack status back to the sequencer
   typedef struct packed {
      op_code_type top_code;
      logic        pop_ok;
      logic        empty;
      logic        full;
   } stk_sts_type;

   // one result word
   typedef struct packed {
      logic [7:0] out_char;
      logic       symbol_valid;
      logic       expression_done;
      logic [2:0] error_code;
      logic       last_result;
   } res_type;

   function automatic logic [1:0] rank_of(input op_code_type code);
      logic [1:0] r;
      case (code)
         CODE_MUL, CODE_DIV: r = 2'd2;
         CODE_ADD, CODE_SUB: r = 2'd1;
         default:            r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] code_char(input op_code_type code);
      logic [7:0] ch;
      case (code)
         CODE_MUL: ch = CH_MUL;
         CODE_DIV: ch = CH_DIV;
         CODE_ADD: ch = CH_ADD;
         CODE_SUB: ch = CH_SUB;
         default:  ch = CH_LPAREN;
      endcase
      return ch;
   endfunction

endpackage

// ===== rtl/itp_stack.sv =====
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_unit_assert.svh"

module itp_stack import itp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  stk_cmd_type cmd,
   output stk_sts_type sts
);

   // entry zero is the implicit '(' sentinel, never stored
   op_code_type       stk_ff [STACK_DEPTH];
   logic [TOP_W-1:0]  top_ff;
   logic [TOP_W-1:0]  top_in;
   logic [TOP_W-1:0]  top_inc;
   logic [1:0]        top_rank;

   assign top_inc = top_ff + 1'b1;

   // pointer update
   always_comb begin
      top_in = top_ff;
      if (cmd.clear) begin
         top_in = '0;
      end else if (cmd.push) begin
         top_in = top_inc;
      end else if (cmd.pop) begin
         top_in = top_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
      end else begin
         top_ff <= top_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (cmd.push && !cmd.clear) begin
         stk_ff[top_inc] <= cmd.code;
      end
   end

   // shared rank compare on the top entry
   assign top_rank     = rank_of(stk_ff[top_ff]);
   assign sts.top_code = stk_ff[top_ff];
   assign sts.empty    = (top_ff == '0);
   assign sts.full     = (top_ff == TOP_W'(STACK_DEPTH - 1));
   assign sts.pop_ok   = !sts.empty && (top_rank != 2'd0) && (top_rank >= cmd.min_rank);

   `ITP_ASSERT_IMP(a_push_not_full, cmd.push, top_ff != TOP_W'(STACK_DEPTH - 1))
   `ITP_ASSERT_IMP(a_pop_not_empty, cmd.pop, top_ff != '0)
   `ITP_ASSERT_IMP(a_single_op, cmd.push, !cmd.pop && !cmd.clear)
   `ITP_ASSERT_NXT(a_clear_empties, cmd.clear, top_ff == '0)

endmodule

// ===== rtl/itp_ctrl.sv =====
`timescale 1ns / 1ps

module itp_ctrl import itp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char,
   output stk_cmd_type stk_cmd,
   input  stk_sts_type stk_sts,
   output logic        res_valid,
   input  logic        res_ready,
   output res_type     res
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_POP   = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   typedef enum logic [2:0] {
      CLS_OPERAND,
      CLS_OP,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_EQ,
      CLS_BAD
   } cls_type;

   state_type   state_ff, state_in;
   cls_type     cls_ff, cls_in;
   op_code_type code_ff, code_in;
   logic [1:0]  rank_ff, rank_in;
   logic        hold_valid_ff, hold_valid_in;
   logic [7:0]  hold_char_ff, hold_char_in;
   logic        term_valid_ff, term_valid_in;
   logic [7:0]  term_char_ff, term_char_in;
   logic        term_sym_ff, term_sym_in;
   logic        term_done_ff, term_done_in;
   logic [2:0]  term_err_ff, term_err_in;
   cls_type     req_cls;
   op_code_type req_code;

   function automatic cls_type classify(input logic [7:0] c);
      cls_type k;
      if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
          (c >= 8'h41 && c <= 8'h5A) || c == CH_DOT) begin
         k = CLS_OPERAND;
      end else if (c == CH_MUL || c == CH_DIV || c == CH_ADD || c == CH_SUB) begin
         k = CLS_OP;
      end else if (c == CH_LPAREN) begin
         k = CLS_OPEN;
      end else if (c == CH_RPAREN) begin
         k = CLS_CLOSE;
      end else if (c == CH_EQ) begin
         k = CLS_EQ;
      end else begin
         k = CLS_BAD;
      end
      return k;
   endfunction

   function automatic op_code_type encode(input logic [7:0] c);
      op_code_type k;
      case (c)
         CH_MUL:  k = CODE_MUL;
         CH_DIV:  k = CODE_DIV;
         CH_ADD:  k = CODE_ADD;
         CH_SUB:  k = CODE_SUB;
         default: k = CODE_LPAREN;
      endcase
      return k;
   endfunction

   assign req_cls  = classify(req_char);
   assign req_code = encode(req_char);
   assign req_ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cls_in        = cls_ff;
      code_in       = code_ff;
      rank_in       = rank_ff;
      hold_valid_in = hold_valid_ff;
      hold_char_in  = hold_char_ff;
      term_valid_in = term_valid_ff;
      term_char_in  = term_char_ff;
      term_sym_in   = term_sym_ff;
      term_done_in  = term_done_ff;
      term_err_in   = term_err_ff;

      stk_cmd.push     = 1'b0;
      stk_cmd.pop      = 1'b0;
      stk_cmd.clear    = 1'b0;
      stk_cmd.code     = code_ff;
      stk_cmd.min_rank = rank_ff;

      res_valid           = 1'b0;
      res.out_char        = hold_char_ff;
      res.symbol_valid    = 1'b1;
      res.expression_done = 1'b0;
      res.error_code      = ERR_NONE;
      res.last_result     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cls_in        = req_cls;
               code_in       = req_code;
               hold_valid_in = 1'b0;
               term_valid_in = 1'b0;
               term_char_in  = 8'h00;
               term_sym_in   = 1'b0;
               term_done_in  = 1'b0;
               term_err_in   = ERR_NONE;
               state_in      = ST_POP;
               case (req_cls)
                  CLS_OPERAND: begin
                     term_valid_in = 1'b1;
                     term_char_in  = req_char;
                     term_sym_in   = 1'b1;
                     state_in      = ST_FLUSH;
                  end
                  CLS_BAD: begin
                     term_valid_in = 1'b1;
                     term_err_in   = ERR_INVALID;
                     stk_cmd.clear = 1'b1;
                     state_in      = ST_FLUSH;
                  end
                  CLS_OP: begin
                     rank_in = rank_of(req_code);
                  end
                  CLS_OPEN: begin
                     rank_in = RANK_NONE;
                  end
                  default: begin
                     rank_in = 2'd1;
                  end
               endcase
            end
         end

         ST_POP: begin
            if (stk_sts.pop_ok) begin
               // pop one operator; the held one goes out as a non-final word
               if (!hold_valid_ff || res_ready) begin
                  res_valid     = hold_valid_ff;
                  hold_valid_in = 1'b1;
                  hold_char_in  = code_char(stk_sts.top_code);
                  stk_cmd.pop   = 1'b1;
               end
            end else begin
               state_in = ST_FLUSH;
               case (cls_ff)
                  CLS_OP, CLS_OPEN: begin
                     if (stk_sts.full) begin
                        term_valid_in = 1'b1;
                        term_err_in   = ERR_OVERFLOW;
                        stk_cmd.clear = 1'b1;
                     end else begin
                        stk_cmd.push = 1'b1;
                     end
                  end
                  CLS_CLOSE: begin
                     if (stk_sts.empty) begin
                        term_valid_in = 1'b1;
                        term_err_in   = ERR_UNMATCHED;
                        stk_cmd.clear = 1'b1;
                     end else begin
                        // drop the matching '('
                        stk_cmd.pop = 1'b1;
                     end
                  end
                  CLS_EQ: begin
                     term_valid_in = 1'b1;
                     stk_cmd.clear = 1'b1;
                     if (stk_sts.empty) begin
                        term_done_in = 1'b1;
                     end else begin
                        term_err_in = ERR_UNCLOSED;
                     end
                  end
                  default: begin
                     state_in = ST_FLUSH;
                  end
               endcase
            end
         end

         ST_FLUSH: begin
            if (hold_valid_ff) begin
               res_valid       = 1'b1;
               res.last_result = !term_valid_ff;
               if (res_ready) begin
                  hold_valid_in = 1'b0;
               end
            end else if (term_valid_ff) begin
               res_valid           = 1'b1;
               res.out_char        = term_char_ff;
               res.symbol_valid    = term_sym_ff;
               res.expression_done = term_done_ff;
               res.error_code      = term_err_ff;
               res.last_result     = 1'b1;
               if (res_ready) begin
                  term_valid_in = 1'b0;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hold_valid_ff <= 1'b0;
         term_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         term_valid_ff <= term_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cls_ff       <= cls_in;
      code_ff      <= code_in;
      rank_ff      <= rank_in;
      hold_char_ff <= hold_char_in;
      term_char_ff <= term_char_in;
      term_sym_ff  <= term_sym_in;
      term_done_ff <= term_done_in;
      term_err_ff  <= term_err_in;
   end

endmodule

// ===== rtl/infix_to_postfix_converter_unit.sv =====
// Infix to postfix converter (shunting-yard) with a 32-entry operator stack.
// req_* : one ASCII character of an infix expression per word; '=' ends it.
// rsp_* : postfix words, one per result; rsp_tlast marks the last word that
//         an input character causes. A pure push ('(' or an operator with
//         nothing to pop) or a ')' with nothing above its '(' causes no word.
// Errors (bad character, unmatched ')', stack overflow, unclosed '(') give
// one error word and reset the stack, as '=' also does.
// One input character is taken at a time; req_tready is low while it works.
// An operand or bad character gives a single word from ST_FLUSH. An operator
// or ')' first pops entries in ST_POP, then pushes itself or drops the
// matching '('; '=' pops operators, then gives its done or error word.
// The sequencer pops one stack entry per cycle, while the output takes
// words, through a single rank compare on the stack top.
// A stalled rsp_tready holds the output register and then stalls the
// sequencer; nothing is dropped. Reset is synchronous: the stack is empty
// (only the '(' sentinel), no word is pending and the block is ready.
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit import itp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [4:0] rsp_tuser,   // [0] symbol_valid, [1] expression_done, [4:2] error_code
   output logic       rsp_tlast    // last_result
);

   stk_cmd_type stk_cmd;
   stk_sts_type stk_sts;
   logic        res_valid;
   logic        res_ready;
   res_type     res;
   logic        rsp_valid_ff, rsp_valid_in;
   res_type     rsp_data_ff;

   itp_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .sts   (stk_sts)
   );

   itp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_char  (req_tdata),
      .stk_cmd   (stk_cmd),
      .stk_sts   (stk_sts),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff.out_char;
   assign rsp_tuser  = {rsp_data_ff.error_code, rsp_data_ff.expression_done,
                        rsp_data_ff.symbol_valid};
   assign rsp_tlast  = rsp_data_ff.last_result;

endmodule
